### rtl/sorted_deadline_timer_queue_top_defines.svh
// Assertion macros for the sorted deadline timer queue.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SDTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SDTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sdtq_pkg.sv
// Shared types, constants and helpers for the sorted deadline timer queue.
// No dependencies; used by the entry RAM, the controller and the top level.
package sdtq_pkg;

  localparam int DEPTH      = 16;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int DL_W       = 32;
  localparam int TAG_W      = 16;
  localparam int DLY_CFG_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - (1 + TAG_W + DL_W + 1);

  // Request codes
  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESCHED_EN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESCHED_DLY = 1'd1;

  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_FIRED    = 2'd1,
    KIND_SCAN_END = 2'd2
  } kind_t;

  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    logic                 resched_en;
    logic [DLY_CFG_W-1:0] resched_dly;
  } cfg_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0] a,
                                              input logic [DL_W-1:0] b);
    logic [DL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DL_W] ? '1 : s[DL_W-1:0];
  endfunction

endpackage

### rtl/sdtq_entry_ram.sv
// Entry store: DEPTH deadline/tag pairs, one write and one read port.
// Registered read; depends on sdtq_pkg.
module sdtq_entry_ram (
  input  logic              clk,
  input  sdtq_pkg::mem_req_t mem_req,
  output sdtq_pkg::entry_t  rd_data
);
  import sdtq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    // hold read data between reads
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/sdtq_ctrl.sv
// Queue controller: circular sorted list in the entry RAM, insert walk and
// expiry scan, plus the result register. Depends on sdtq_pkg.
module sdtq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sdtq_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req,
  input  logic [sdtq_pkg::DL_W-1:0]    in_now,
  input  logic [sdtq_pkg::DL_W-1:0]    in_delay,
  input  logic [sdtq_pkg::TAG_W-1:0]   in_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sdtq_pkg::kind_t              out_kind,
  output logic                         out_ovf,
  output logic [sdtq_pkg::TAG_W-1:0]   out_tag,
  output logic [sdtq_pkg::DL_W-1:0]    out_dl,
  output logic                         out_arm,
  output logic                         out_last,
  output sdtq_pkg::mem_req_t           mem_req,
  input  sdtq_pkg::entry_t             rd_data
);
  import sdtq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_BEGIN,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_SET_ACK,
    ST_EXP_RD,
    ST_EXP_CHK
  } state_t;

  state_t            state_r, state_nxt;
  logic              req_r, req_nxt;
  logic [DL_W-1:0]   now_r, now_nxt;
  logic [DL_W-1:0]   new_dl_r, new_dl_nxt;
  logic [TAG_W-1:0]  new_tag_r, new_tag_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  p_r, p_nxt;
  logic [PTR_W-1:0]  w_r, w_nxt;
  logic [PTR_W-1:0]  j_r, j_nxt;
  logic              dropped_r, dropped_nxt;
  logic              is_head_r, is_head_nxt;
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic [TAG_W-1:0]  out_tag_r, out_tag_nxt;
  logic [DL_W-1:0]   out_dl_r, out_dl_nxt;
  logic              out_arm_r, out_arm_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic              accept;
  logic [DL_W-1:0]   add_b;
  entry_t            new_entry;
  entry_t            no_entry;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign add_b     = (in_req == REQ_SET) ? in_delay : DL_W'(cfg.resched_dly);
  assign new_entry = '{deadline: new_dl_r, tag: new_tag_r};
  assign no_entry  = '{deadline: '0, tag: '0};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    now_nxt       = now_r;
    new_dl_nxt    = new_dl_r;
    new_tag_nxt   = new_tag_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    w_nxt         = w_r;
    j_nxt         = j_r;
    dropped_nxt   = dropped_r;
    is_head_nxt   = is_head_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_ovf_nxt   = out_ovf_r;
    out_tag_nxt   = out_tag_r;
    out_dl_nxt    = out_dl_r;
    out_arm_nxt   = out_arm_r;
    out_last_nxt  = out_last_r;
    mem_req       = '{rd_en: 1'b0, rd_addr: '0, wr_en: 1'b0, wr_addr: '0,
                      wr_data: no_entry};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt     = in_req;
          now_nxt     = in_now;
          new_dl_nxt  = sat_add(in_now, add_b);
          new_tag_nxt = (in_req == REQ_SET) ? in_tag : '0;
          dropped_nxt = 1'b0;
          is_head_nxt = 1'b0;
          if (in_req == REQ_SET || cfg.resched_en) begin
            state_nxt = ST_INS_BEGIN;
          end else begin
            state_nxt = ST_EXP_RD;
          end
        end
      end

      ST_INS_BEGIN: begin
        if (cnt_r == CNT_W'(DEPTH)) begin
          dropped_nxt = 1'b1;
          state_nxt   = (req_r == REQ_SET) ? ST_SET_ACK : ST_EXP_RD;
        end else if (cnt_r == '0) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = tail_r;
          mem_req.wr_data = new_entry;
          is_head_nxt     = 1'b1;
          cnt_nxt         = cnt_r + CNT_W'(1);
          tail_nxt        = ptr_inc(tail_r);
          state_nxt       = (req_r == REQ_SET) ? ST_SET_ACK : ST_EXP_RD;
        end else begin
          // start the backward walk at the last entry
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr_dec(tail_r);
          p_nxt           = ptr_dec(tail_r);
          w_nxt           = tail_r;
          j_nxt           = PTR_W'(cnt_r - CNT_W'(1));
          state_nxt       = ST_INS_SHIFT;
        end
      end

      ST_INS_SHIFT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = w_r;
        if (rd_data.deadline > new_dl_r) begin
          // move the later entry up one slot
          mem_req.wr_data = rd_data;
          if (j_r == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ptr_dec(p_r);
            w_nxt           = p_r;
            p_nxt           = ptr_dec(p_r);
            j_nxt           = j_r - PTR_W'(1);
          end
        end else begin
          mem_req.wr_data = new_entry;
          is_head_nxt     = 1'b0;
          cnt_nxt         = cnt_r + CNT_W'(1);
          tail_nxt        = ptr_inc(tail_r);
          state_nxt       = (req_r == REQ_SET) ? ST_SET_ACK : ST_EXP_RD;
        end
      end

      ST_INS_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = p_r;
        mem_req.wr_data = new_entry;
        is_head_nxt     = 1'b1;
        cnt_nxt         = cnt_r + CNT_W'(1);
        tail_nxt        = ptr_inc(tail_r);
        state_nxt       = (req_r == REQ_SET) ? ST_SET_ACK : ST_EXP_RD;
      end

      ST_SET_ACK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACK;
          out_ovf_nxt   = dropped_r;
          out_tag_nxt   = '0;
          out_dl_nxt    = '0;
          out_arm_nxt   = is_head_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_EXP_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = head_r;
        state_nxt       = ST_EXP_CHK;
      end

      ST_EXP_CHK: begin
        if (out_free) begin
          if (cnt_r != '0 && rd_data.deadline <= now_r) begin
            // pop the head and fetch the next one
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = KIND_FIRED;
            out_ovf_nxt     = 1'b0;
            out_tag_nxt     = rd_data.tag;
            out_dl_nxt      = rd_data.deadline;
            out_arm_nxt     = 1'b0;
            out_last_nxt    = 1'b0;
            head_nxt        = ptr_inc(head_r);
            cnt_nxt         = cnt_r - CNT_W'(1);
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ptr_inc(head_r);
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_SCAN_END;
            out_ovf_nxt   = dropped_r;
            out_tag_nxt   = '0;
            out_dl_nxt    = '0;
            out_arm_nxt   = (cnt_r != '0);
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    now_r      <= now_nxt;
    new_dl_r   <= new_dl_nxt;
    new_tag_r  <= new_tag_nxt;
    p_r        <= p_nxt;
    w_r        <= w_nxt;
    j_r        <= j_nxt;
    dropped_r  <= dropped_nxt;
    is_head_r  <= is_head_nxt;
    out_kind_r <= out_kind_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_tag_r  <= out_tag_nxt;
    out_dl_r   <= out_dl_nxt;
    out_arm_r  <= out_arm_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_ovf   = out_ovf_r;
  assign out_tag   = out_tag_r;
  assign out_dl    = out_dl_r;
  assign out_arm   = out_arm_r;
  assign out_last  = out_last_r;

endmodule

### rtl/sorted_deadline_timer_queue_top.sv
// Channel  | Beat contents                                   | Direction
// in_      | tuser: req_type; tdata: now, delay, tag         | slave
// out_     | tuser: kind; tlast: last; tdata: ovf..arm_timer  | master
// cfg_     | index, data (resched_enable, resched_delay)     | write only
//
// Set request: acknowledged once the insert is done; the insert walks backward
// from the tail through the entry RAM, one entry moved per cycle on its single
// write port.
// Tick: same insert when reschedule is on, then an expiry scan that fires each
// expired entry in turn, paced by the registered RAM read of the head.
// Synchronous active-low reset; no clearing pass, the entry count masks stale
// slots. A stalled result holds the controller until the beat is taken.
//
// Top level: configuration registers, controller and entry RAM.
// Depends on sdtq_pkg, sdtq_ctrl, sdtq_entry_ram and the assertion macros.
`include "sorted_deadline_timer_queue_top_defines.svh"

module sorted_deadline_timer_queue_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sdtq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdtq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sdtq_pkg::IN_DATA_W-1:0]   in_tdata,   // now, delay, tag
  input  logic [0:0]                       in_tuser,   // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sdtq_pkg::OUT_DATA_W-1:0]  out_tdata,  // overflow, fired_tag,
                                                        // fired_deadline, arm_timer
  output logic [1:0]                       out_tuser,  // kind
  output logic                             out_tlast
);
  import sdtq_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  mem_req_t          mem_req;
  entry_t            rd_data;
  kind_t             out_kind;
  logic              out_ovf;
  logic [TAG_W-1:0]  out_tag;
  logic [DL_W-1:0]   out_dl;
  logic              out_arm;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RESCHED_EN:  cfg_nxt.resched_en  = cfg_data[0];
        REG_RESCHED_DLY: cfg_nxt.resched_dly = cfg_data[DLY_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{resched_en: 1'b1, resched_dly: DLY_CFG_W'(1)};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sdtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser[0]),
    .in_now    (in_tdata[DL_W-1:0]),
    .in_delay  (in_tdata[2*DL_W-1:DL_W]),
    .in_tag    (in_tdata[2*DL_W+TAG_W-1:2*DL_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_ovf   (out_ovf),
    .out_tag   (out_tag),
    .out_dl    (out_dl),
    .out_arm   (out_arm),
    .out_last  (out_tlast),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  sdtq_entry_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  assign out_tuser = out_kind;
  assign out_tdata = {OUT_PAD_W'(0), out_arm, out_dl, out_tag, out_ovf};

  `SDTQ_ASSERT_IMP(a_no_same_addr, mem_req.wr_en && mem_req.rd_en,
                   mem_req.wr_addr != mem_req.rd_addr, "RAM read and write hit one entry")
  `SDTQ_ASSERT_IMP(a_no_write_idle, in_tready, !mem_req.wr_en,
                   "RAM write while idle")
  `SDTQ_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
                   "input taken while an item is in progress")

endmodule

### sim/tb_sorted_deadline_timer_queue_top.sv
// Testbench for sorted_deadline_timer_queue_top: directed table, then random set and tick
// traffic over several register settings, checked beat by beat against a local model.
// Depends on sdtq_pkg and the RTL of the timer queue.
module tb_sorted_deadline_timer_queue_top;
  import sdtq_pkg::*;

  typedef struct packed {
    kind_t            kind;
    logic             ovf;
    logic [TAG_W-1:0] tag;
    logic [DL_W-1:0]  dl;
    logic             arm;
    logic             last;
  } timer_result_t;

  typedef struct packed {
    logic             req;
    logic [DL_W-1:0]  now;
    logic [DL_W-1:0]  dly;
    logic [TAG_W-1:0] tag;
    bit               typed;
    logic             ovf;
    logic             arm;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // now, delay, tag
  logic [0:0]            in_tuser   = '0;  // req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // overflow, fired_tag, fired_deadline, arm_timer
  logic [1:0]            out_tuser;        // kind
  logic                  out_tlast;

  // Model state
  entry_t                timer_list[$];
  bit                    resched_on  = 1'b1;
  logic [DLY_CFG_W-1:0]  resched_gap = 16'd1;
  timer_result_t         due_results[$];

  stim_row_t             directed_rows[$];
  int                    mismatch_count = 0;
  int                    burst_left     = 0;
  int                    hold_cycles    = 0;
  logic [DL_W-1:0]       uptime         = '0;
  timer_result_t         seen_beat;
  timer_result_t         want_beat;

  sorted_deadline_timer_queue_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [DL_W-1:0] deadline_of(input logic [DL_W-1:0] now,
                                                  input logic [DL_W-1:0] dly);
    logic [DL_W:0] s;
    s = {1'b0, now} + {1'b0, dly};
    return s[DL_W] ? '1 : s[DL_W-1:0];
  endfunction

  // Stable insert: goes behind every entry with an equal or earlier deadline.
  task automatic timer_insert(input logic [DL_W-1:0] dl, input logic [TAG_W-1:0] tg,
                              output bit full, output bit at_head);
    int     pos;
    entry_t e;
    full    = timer_list.size() >= DEPTH;
    at_head = 1'b0;
    if (!full) begin
      pos = 0;
      while (pos < timer_list.size() && timer_list[pos].deadline <= dl) pos++;
      e.deadline = dl;
      e.tag      = tg;
      timer_list.insert(pos, e);
      at_head = (pos == 0);
    end
  endtask

  task automatic predict_timer_req(input logic req, input logic [DL_W-1:0] now,
                                   input logic [DL_W-1:0] dly, input logic [TAG_W-1:0] tag);
    timer_result_t r;
    bit            full;
    bit            head;
    r    = '0;
    full = 1'b0;
    if (req == REQ_SET) begin
      timer_insert(deadline_of(now, dly), tag, full, head);
      r.kind = KIND_ACK;
      r.ovf  = full;
      r.arm  = head;
      r.last = 1'b1;
      due_results.push_back(r);
    end else begin
      if (resched_on) timer_insert(deadline_of(now, {16'h0, resched_gap}), '0, full, head);
      while (timer_list.size() > 0 && timer_list[0].deadline <= now) begin
        r      = '0;
        r.kind = KIND_FIRED;
        r.tag  = timer_list[0].tag;
        r.dl   = timer_list[0].deadline;
        due_results.push_back(r);
        void'(timer_list.pop_front());
      end
      r      = '0;
      r.kind = KIND_SCAN_END;
      r.ovf  = full;
      r.arm  = timer_list.size() > 0;
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endtask

  task automatic add_row(input logic req, input logic [DL_W-1:0] now,
                         input logic [DL_W-1:0] dly, input logic [TAG_W-1:0] tag,
                         input bit typed, input logic ovf, input logic arm);
    stim_row_t row;
    row.req   = req;
    row.now   = now;
    row.dly   = dly;
    row.tag   = tag;
    row.typed = typed;
    row.ovf   = ovf;
    row.arm   = arm;
    directed_rows.push_back(row);
  endtask

  // Enter and leave at a rising edge; keep tvalid high across back-to-back beats.
  task automatic push_req(input logic req, input logic [DL_W-1:0] now,
                          input logic [DL_W-1:0] dly, input logic [TAG_W-1:0] tag,
                          input bit nogap);
    int gap;
    bit hs;
    if (!nogap) begin
      if (burst_left <= 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {tag, dly, now};
    do begin
      @(negedge clk);
      hs = in_tvalid && in_tready;
      @(posedge clk);
    end while (!hs);
    predict_timer_req(req, now, dly, tag);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    bit hs;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      hs = cfg_valid && cfg_ready;
      @(posedge clk);
    end while (!hs);
    if (idx == REG_RESCHED_EN) resched_on = data[0];
    else resched_gap = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [DL_W-1:0] exp_v,
                             input logic [DL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // Receiver: draws its stall pattern at random and redraws it periodically; a hold-off request overrides it.
  initial begin
    int          mode;
    int          k;
    logic [15:0] pat;
    mode = 0;
    pat  = '1;
    k    = 0;
    forever begin
      @(posedge clk);
      if (k % 32 == 0) begin
        mode = $urandom_range(0, 2);
        pat  = 16'($urandom);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= pat[k % 16];
          end
          default: begin
            out_tready <= 1'($urandom_range(0, 1));
          end
        endcase
      end
      k++;
    end
  end

  // A beat seen at the falling edge is taken at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_beat.kind = kind_t'(out_tuser);
      seen_beat.ovf  = out_tdata[0];
      seen_beat.tag  = out_tdata[TAG_W:1];
      seen_beat.dl   = out_tdata[TAG_W+DL_W:TAG_W+1];
      seen_beat.arm  = out_tdata[TAG_W+DL_W+1];
      seen_beat.last = out_tlast;
      if (due_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, got %h", $time, seen_beat);
      end else begin
        want_beat = due_results.pop_front();
        check_field("kind", DL_W'(want_beat.kind), DL_W'(seen_beat.kind));
        check_field("overflow", DL_W'(want_beat.ovf), DL_W'(seen_beat.ovf));
        check_field("fired_tag", DL_W'(want_beat.tag), DL_W'(seen_beat.tag));
        check_field("fired_deadline", want_beat.dl, seen_beat.dl);
        check_field("arm_timer", DL_W'(want_beat.arm), DL_W'(seen_beat.arm));
        check_field("last", DL_W'(want_beat.last), DL_W'(seen_beat.last));
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] en_cfg[5];
    logic [CFG_DATA_W-1:0] dly_cfg[5];
    timer_result_t         r;
    logic                  req;
    logic [DL_W-1:0]       dly;
    int                    mode;

    // High bits of the enable word must be ignored.
    en_cfg  = '{16'hFFFE, 16'h0001, 16'h8001, 16'h0000, 16'h0001};
    dly_cfg = '{16'h0000, 16'h0000, 16'hFFFF, 16'h1234, 16'h0001};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: reschedule on, delay 1.
    add_row(REQ_SET,  32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1, 1'b0, 1'b1);
    add_row(REQ_SET,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, 1, 1'b0, 1'b0);
    add_row(REQ_SET,  32'hFFFF_FFFF, 32'h0000_0000, 16'h0002, 1, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h0000_0000, 32'h0000_0000, 16'h8000, 1, 1'b0, 1'b0);
    add_row(REQ_SET,  32'hAAAA_AAAA, 32'h5555_5555, 16'hA5A5, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h5555_5555, 32'h0000_0001, 16'h5A5A, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h0000_0100, 32'h0000_0010, 16'h0011, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h0000_0100, 32'h0000_0010, 16'h0012, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h8000_0000, 32'h8000_0000, 16'h0013, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h0000_0001, 32'hFFFF_FFFE, 16'h7FFF, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h0000_0002, 32'hFFFF_FFFE, 16'h0014, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h0000_0000, 32'h0000_0003, 16'h0015, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h0000_0000, 32'h0000_0001, 16'h0016, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h7FFF_FFFF, 32'h0000_0000, 16'h0017, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h0000_0000, 32'h0000_0002, 16'h0018, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h1234_5678, 32'h0000_0000, 16'h0019, 0, 1'b0, 1'b0);
    // Queue is full now: set is dropped, then the tick drops its reschedule entry.
    add_row(REQ_SET,  32'h0000_0000, 32'h0000_0000, 16'h0000, 1, 1'b1, 1'b0);
    add_row(REQ_TICK, 32'h0000_0000, 32'h0000_0000, 16'h0000, 0, 1'b0, 1'b0);
    add_row(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 1'b0, 1'b0);
    add_row(REQ_TICK, 32'h0000_0007, 32'h0000_0000, 16'h0000, 0, 1'b0, 1'b0);
    add_row(REQ_TICK, 32'h0000_0008, 32'h0000_0000, 16'h0000, 0, 1'b0, 1'b0);
    add_row(REQ_SET,  32'h0000_0005, 32'h0000_0000, 16'h5555, 1, 1'b0, 1'b1);

    foreach (directed_rows[i]) begin
      push_req(directed_rows[i].req, directed_rows[i].now, directed_rows[i].dly,
               directed_rows[i].tag, 1'b0);
      if (directed_rows[i].typed) begin
        r      = '0;
        r.kind = KIND_ACK;
        r.ovf  = directed_rows[i].ovf;
        r.arm  = directed_rows[i].arm;
        r.last = 1'b1;
        due_results[due_results.size()-1] = r;
      end
    end
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_RESCHED_EN, en_cfg[ph]);
      write_reg(REG_RESCHED_DLY, dly_cfg[ph]);
      if (ph == 0) begin
        // Stall the receiver while sets keep coming; the sets outnumber the entries, so the queue fills and overflows.
        hold_cycles = 300;
        repeat (20) push_req(REQ_SET, uptime, $urandom_range(0, 200), TAG_W'($urandom), 1'b1);
      end
      for (int i = 0; i < 36; i++) begin
        if (ph == 2 && i == 18) wait_drained();
        mode = $urandom_range(0, 31);
        if (mode == 0) uptime = $urandom;
        else if (mode == 1) uptime = 32'hFFFF_FFFF - $urandom_range(0, 300);
        else uptime = uptime + $urandom_range(0, 20);
        req = ($urandom_range(0, 3) == 0) ? REQ_TICK : REQ_SET;
        case ($urandom_range(0, 9))
          0: begin
            dly = $urandom;
          end
          1: begin
            dly = '1;
          end
          2: begin
            dly = '0;
          end
          default: begin
            dly = $urandom_range(0, 60);
          end
        endcase
        push_req(req, uptime, dly, TAG_W'($urandom), 1'b0);
      end
      wait_drained();
    end

    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
